// ----- sv/sgci_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial GPIO command interpreter package
// Shared types, character codes and hex helpers for the interpreter.
// ----------------------------------------------------------------------------
package sgci_pkg;

    // Width of every pin bank field
    localparam int PIN_W = 28;

    // Command and response characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_UR    = 8'h52;  // 'R'
    localparam logic [7:0] CH_UV    = 8'h56;  // 'V'
    localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF_HX = 8'h66;  // 'f'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_D0    = 8'h30;  // '0'
    localparam logic [7:0] CH_D1    = 8'h31;  // '1'
    localparam logic [7:0] CH_D9    = 8'h39;  // '9'
    localparam logic [7:0] CH_UI    = 8'h49;  // 'I'
    localparam logic [7:0] CH_UO    = 8'h4F;  // 'O'
    localparam logic [7:0] CH_UU    = 8'h55;  // 'U'
    localparam logic [7:0] CH_UD    = 8'h44;  // 'D'
    localparam logic [7:0] CH_UN    = 8'h4E;  // 'N'
    localparam logic [7:0] CH_UK    = 8'h4B;  // 'K'
    localparam logic [3:0] NIB_MASK = 4'hF;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0]       rx_byte;
        logic [PIN_W-1:0] pin_levels;
        logic [7:0]       spi_rx_byte;
    } t_in;

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             last;
        logic [PIN_W-1:0] pin_dir;
        logic [PIN_W-1:0] pin_out;
        logic [PIN_W-1:0] pull_up_en;
        logic [PIN_W-1:0] pull_down_en;
        logic             spi_enabled;
        logic             spi_strobe;
        logic [7:0]       spi_tx_byte;
    } t_out;

    // Interpreter state
    typedef struct packed {
        t_phase           phase;
        logic [4:0]       cur_pin;
        logic [3:0]       high_nibble;
        logic [PIN_W-1:0] dir_bits;
        logic [PIN_W-1:0] level_bits;
        logic [PIN_W-1:0] pullup_bits;
        logic [PIN_W-1:0] pulldown_bits;
        logic             spi_on;
    } t_state;

    // Response of one command byte: up to four characters
    typedef struct packed {
        logic            has_tx;
        logic [1:0]      last_idx;
        logic [3:0][7:0] chars;
        logic            strobe;
        logic [7:0]      stx;
    } t_resp;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CH_D0 && c <= CH_D9) begin
            v = 4'(c - CH_D0);
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF_HX) begin
            v = 4'(c - CH_LA + 8'd10);
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v >= 4'd10) begin
            r = CH_UA + {4'd0, v} - 8'd10;
        end else begin
            r = CH_D0 + {4'd0, v};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sgci_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial GPIO command decoder
// Computes the next interpreter state and the response of one command byte.
// ----------------------------------------------------------------------------
module sgci_decode #(
    parameter int NUM_PINS = 28
) (
    input  wire sgci_pkg::t_state                   i_st,
    input  wire logic [7:0]                         i_c,
    input  wire logic [sgci_pkg::PIN_W-1:0]         i_levels,
    input  wire logic [7:0]                         i_srx,
    output sgci_pkg::t_state                        o_st,
    output sgci_pkg::t_resp                         o_resp
);

    localparam logic [8:0] LETTER_END = 9'(sgci_pkg::CH_LA) + 9'(NUM_PINS);
    localparam logic [5:0] BANK_SIZE  = 6'(NUM_PINS);

    logic [sgci_pkg::PIN_W-1:0] pin_mask;
    logic                       is_letter;
    logic                       is_pin_cmd;
    logic [5:0]                 pin_inc;
    logic [4:0]                 pin_next;

    // Pins at or above the field width select nothing
    assign pin_mask  = {{(sgci_pkg::PIN_W-1){1'b0}}, 1'b1} << i_st.cur_pin;
    assign is_letter = (i_c >= sgci_pkg::CH_LA) && ({1'b0, i_c} < LETTER_END);
    assign is_pin_cmd = (i_c == sgci_pkg::CH_D0) || (i_c == sgci_pkg::CH_D1)
                     || (i_c == sgci_pkg::CH_UI) || (i_c == sgci_pkg::CH_UO)
                     || (i_c == sgci_pkg::CH_QUERY) || (i_c == sgci_pkg::CH_UU)
                     || (i_c == sgci_pkg::CH_UD) || (i_c == sgci_pkg::CH_UN);
    assign pin_inc  = {1'b0, i_st.cur_pin} + 6'd1;
    assign pin_next = (pin_inc >= BANK_SIZE) ? 5'd0 : pin_inc[4:0];

    always_comb begin
        o_st            = i_st;
        o_resp.has_tx   = 1'b0;
        o_resp.last_idx = 2'd0;
        o_resp.chars    = '0;
        o_resp.strobe   = 1'b0;
        o_resp.stx      = 8'd0;
        priority if (i_c == sgci_pkg::CH_CR || i_c == sgci_pkg::CH_LF) begin
            // drop line endings in every phase
            o_st = i_st;
        end else if (i_c == sgci_pkg::CH_UV) begin
            o_st.phase = sgci_pkg::PH_IDLE;
        end else if (i_c == sgci_pkg::CH_UR) begin
            o_st.cur_pin       = 5'd0;
            o_st.dir_bits      = '0;
            o_st.pullup_bits   = '0;
            o_st.pulldown_bits = '0;
            o_st.spi_on        = 1'b0;
            o_st.phase         = sgci_pkg::PH_IDLE;
            o_resp.has_tx      = 1'b1;
            o_resp.last_idx    = 2'd1;
            o_resp.chars[0]    = sgci_pkg::CH_UO;
            o_resp.chars[1]    = sgci_pkg::CH_UK;
        end else if (i_st.phase == sgci_pkg::PH_HIGH) begin
            o_st.high_nibble = sgci_pkg::hex_value(i_c);
            o_st.phase       = sgci_pkg::PH_LOW;
        end else if (i_st.phase == sgci_pkg::PH_LOW) begin
            o_resp.stx      = {i_st.high_nibble & sgci_pkg::NIB_MASK,
                               sgci_pkg::hex_value(i_c)};
            o_resp.strobe   = 1'b1;
            o_st.spi_on     = 1'b1;
            o_resp.has_tx   = 1'b1;
            o_resp.last_idx = 2'd1;
            o_resp.chars[0] = sgci_pkg::hex_char(i_srx[7:4]);
            o_resp.chars[1] = sgci_pkg::hex_char(i_srx[3:0]);
            o_st.phase      = sgci_pkg::PH_IDLE;
        end else begin
            o_st.phase = sgci_pkg::PH_IDLE;
            if (is_letter) begin
                o_st.cur_pin = 5'(i_c - sgci_pkg::CH_LA);
            end else if (is_pin_cmd) begin
                unique case (i_c)
                    sgci_pkg::CH_UI: begin
                        o_st.dir_bits      = i_st.dir_bits & ~pin_mask;
                        o_st.pullup_bits   = i_st.pullup_bits & ~pin_mask;
                        o_st.pulldown_bits = i_st.pulldown_bits & ~pin_mask;
                    end
                    sgci_pkg::CH_UO: o_st.dir_bits   = i_st.dir_bits | pin_mask;
                    sgci_pkg::CH_D0: o_st.level_bits = i_st.level_bits & ~pin_mask;
                    sgci_pkg::CH_D1: o_st.level_bits = i_st.level_bits | pin_mask;
                    sgci_pkg::CH_UU: begin
                        o_st.pullup_bits   = i_st.pullup_bits | pin_mask;
                        o_st.pulldown_bits = i_st.pulldown_bits & ~pin_mask;
                    end
                    sgci_pkg::CH_UD: begin
                        o_st.pulldown_bits = i_st.pulldown_bits | pin_mask;
                        o_st.pullup_bits   = i_st.pullup_bits & ~pin_mask;
                    end
                    sgci_pkg::CH_UN: begin
                        o_st.pullup_bits   = i_st.pullup_bits & ~pin_mask;
                        o_st.pulldown_bits = i_st.pulldown_bits & ~pin_mask;
                    end
                    sgci_pkg::CH_QUERY: begin
                        o_resp.has_tx   = 1'b1;
                        o_resp.last_idx = 2'd3;
                        o_resp.chars[0] = sgci_pkg::CH_LA + {3'd0, i_st.cur_pin};
                        o_resp.chars[1] = (|(i_levels & pin_mask)) ?
                                          sgci_pkg::CH_D1 : sgci_pkg::CH_D0;
                        o_resp.chars[2] = sgci_pkg::CH_CR;
                        o_resp.chars[3] = sgci_pkg::CH_LF;
                    end
                    default: o_st.cur_pin = i_st.cur_pin;
                endcase
                o_st.cur_pin = pin_next;
            end else if (i_c == sgci_pkg::CH_TILDE) begin
                o_st.phase = sgci_pkg::PH_HIGH;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/serial_gpio_command_interpreter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial GPIO command interpreter
// Decodes ASCII command bytes into pin bank settings, SPI byte transfers and
// ASCII responses.
// ----------------------------------------------------------------------------
// Each command byte is decoded in the cycle it is accepted: the pin bank,
// the latched pin and the parser phase update at that edge, and the
// response characters go into a result register. A byte produces one to four
// result transactions (four for '?', two for 'R' and for a finished '~'
// transfer, one with tx_valid low otherwise), one per cycle while the
// downstream side does not stall. The next command byte is taken in the same
// cycle as the final result transaction of the previous byte, so a byte
// occupies the block until its final result transaction is taken. Every
// result transaction carries the pin bank state after its command byte.
// The SPI strobe and the transmitted SPI byte appear on the first result
// transaction of the byte that completes a '~' sequence; spi_rx_byte is
// sampled from that same input transaction.
// ----------------------------------------------------------------------------
module serial_gpio_command_interpreter_top #(
    parameter int NUM_PINS = 28
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire sgci_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output sgci_pkg::t_out      o_out_data
);

    sgci_pkg::t_state r_state;
    sgci_pkg::t_state n_state;
    sgci_pkg::t_resp  r_resp;
    sgci_pkg::t_resp  n_resp;
    logic             r_busy;
    logic [1:0]       r_idx;

    logic in_take;
    logic out_take;
    logic out_last;

    // Decode the incoming byte against the current state
    sgci_decode #(
        .NUM_PINS (NUM_PINS)
    ) u_decode (
        .i_st     (r_state),
        .i_c      (i_in_data.rx_byte),
        .i_levels (i_in_data.pin_levels),
        .i_srx    (i_in_data.spi_rx_byte),
        .o_st     (n_state),
        .o_resp   (n_resp)
    );

    assign out_last   = (r_idx == r_resp.last_idx);
    assign out_take   = r_busy && !i_out_stall;
    // Hold the input until the final result transaction leaves
    assign o_in_stall = r_busy && !(out_take && out_last);
    assign in_take    = i_in_valid && !o_in_stall;

    // Interpreter state: advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= sgci_pkg::PH_IDLE;
            r_state.cur_pin       <= 5'd0;
            r_state.high_nibble   <= 4'd0;
            r_state.dir_bits      <= '0;
            r_state.level_bits    <= '0;
            r_state.pullup_bits   <= '0;
            r_state.pulldown_bits <= '0;
            r_state.spi_on        <= 1'b0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Result sequencer: step through the response characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (in_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (out_take) begin
            if (out_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Response payload, loaded with each accepted byte
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_resp <= n_resp;
        end
    end

    assign o_out_valid = r_busy;

    always_comb begin
        o_out_data.tx_valid     = r_resp.has_tx;
        o_out_data.tx_byte      = r_resp.has_tx ? r_resp.chars[r_idx] : 8'd0;
        o_out_data.last         = out_last;
        o_out_data.pin_dir      = r_state.dir_bits;
        o_out_data.pin_out      = r_state.level_bits;
        o_out_data.pull_up_en   = r_state.pullup_bits;
        o_out_data.pull_down_en = r_state.pulldown_bits;
        o_out_data.spi_enabled  = r_state.spi_on;
        o_out_data.spi_strobe   = r_resp.strobe && (r_idx == 2'd0);
        o_out_data.spi_tx_byte  = (r_resp.strobe && (r_idx == 2'd0)) ? r_resp.stx : 8'd0;
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_resp.last_idx))
        else $error("result index beyond response length");

    a_silent_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.tx_valid) |-> o_out_data.last)
        else $error("silent result transaction not marked last");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> o_in_stall)
        else $error("input accepted while response pending");

    a_pin_in_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (o_out_valid && ({1'b0, r_state.cur_pin} < 6'(NUM_PINS))))
        else $error("latched pin outside bank or result missing");
`endif

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Serial GPIO command interpreter testbench
// Feeds ASCII command bytes with random pin levels and SPI return bytes, keeps
// its own copy of the pin bank and parser, and checks every response
// transaction field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PINS = 28;
    localparam int PIN_W    = sgci_pkg::PIN_W;

    // Letter of the last pin, the first letter past the bank, and two bytes
    // that are not hex digits
    localparam logic [7:0] LAST_PIN_CH   = sgci_pkg::CH_LA + 8'(NUM_PINS - 1);
    localparam logic [7:0] BEYOND_PIN_CH = sgci_pkg::CH_LA + 8'(NUM_PINS);
    localparam logic [7:0] BAD_LOWER     = sgci_pkg::CH_LF_HX + 8'd1;  // 'g'
    localparam logic [7:0] BAD_UPPER     = 8'h5A;                      // 'Z'

    localparam logic [7:0] PIN_CMDS [8] = '{sgci_pkg::CH_UI, sgci_pkg::CH_UO,
                                            sgci_pkg::CH_D0, sgci_pkg::CH_D1,
                                            sgci_pkg::CH_UU, sgci_pkg::CH_UD,
                                            sgci_pkg::CH_UN, sgci_pkg::CH_QUERY};

    // ------------------------------------------------------------------------
    // Scoreboard: tracks parser and pin bank state, predicts the response
    // transactions of each accepted command byte and checks them in order.
    // ------------------------------------------------------------------------
    class command_scoreboard;
        sgci_pkg::t_phase phase;
        logic [4:0]       pin;
        logic [3:0]       hi_nib;
        logic [PIN_W-1:0] dir, lvl, pu, pd;
        logic             spi_on;
        sgci_pkg::t_out   expected_responses[$];
        int               errors, commands, responses, transfers, queries;

        function new();
            phase  = sgci_pkg::PH_IDLE;
            pin    = '0;
            hi_nib = '0;
            dir    = '0;
            lvl    = '0;
            pu     = '0;
            pd     = '0;
            spi_on = 1'b0;
        endfunction

        // Hex digit value of a character; anything else reads as zero
        function logic [3:0] nibble_of(logic [7:0] c);
            if (c >= sgci_pkg::CH_D0 && c <= sgci_pkg::CH_D9) begin
                return 4'(c - sgci_pkg::CH_D0);
            end
            if (c >= sgci_pkg::CH_UA && c <= sgci_pkg::CH_UF) begin
                return 4'(c - sgci_pkg::CH_UA) + 4'd10;
            end
            if (c >= sgci_pkg::CH_LA && c <= sgci_pkg::CH_LF_HX) begin
                return 4'(c - sgci_pkg::CH_LA) + 4'd10;
            end
            return 4'd0;
        endfunction

        function logic [7:0] hex_digit(logic [3:0] v);
            return (v >= 4'd10) ? sgci_pkg::CH_UA + 8'(v - 4'd10)
                                : sgci_pkg::CH_D0 + 8'(v);
        endfunction

        function void take_command(sgci_pkg::t_in d);
            logic [7:0]       c;
            logic [7:0]       chars [4];
            int               n, cnt;
            logic             strobe, acted;
            logic [7:0]       stx;
            logic [PIN_W-1:0] b;
            sgci_pkg::t_out   r;
            c      = d.rx_byte;
            n      = 0;
            strobe = 1'b0;
            stx    = '0;
            acted  = 1'b0;
            b      = {{(PIN_W-1){1'b0}}, 1'b1} << pin;
            commands++;
            if (c == sgci_pkg::CH_CR || c == sgci_pkg::CH_LF) begin
                // dropped in every phase
            end else if (c == sgci_pkg::CH_UV) begin
                phase = sgci_pkg::PH_IDLE;
            end else if (c == sgci_pkg::CH_UR) begin
                pin    = '0;
                dir    = '0;
                pu     = '0;
                pd     = '0;
                spi_on = 1'b0;
                phase  = sgci_pkg::PH_IDLE;
                chars[0] = sgci_pkg::CH_UO;
                chars[1] = sgci_pkg::CH_UK;
                n = 2;
            end else if (phase == sgci_pkg::PH_HIGH) begin
                hi_nib = nibble_of(c);
                phase  = sgci_pkg::PH_LOW;
            end else if (phase == sgci_pkg::PH_LOW) begin
                stx      = {hi_nib, nibble_of(c)};
                strobe   = 1'b1;
                spi_on   = 1'b1;
                chars[0] = hex_digit(d.spi_rx_byte[7:4]);
                chars[1] = hex_digit(d.spi_rx_byte[3:0]);
                n        = 2;
                phase    = sgci_pkg::PH_IDLE;
                transfers++;
            end else begin
                phase = sgci_pkg::PH_IDLE;
                if (c >= sgci_pkg::CH_LA && c <= LAST_PIN_CH) begin
                    pin = 5'(c - sgci_pkg::CH_LA);
                end else if (c == sgci_pkg::CH_TILDE) begin
                    phase = sgci_pkg::PH_HIGH;
                end else begin
                    acted = 1'b1;
                    case (c)
                        sgci_pkg::CH_UI: begin
                            dir &= ~b;
                            pu  &= ~b;
                            pd  &= ~b;
                        end
                        sgci_pkg::CH_UO: dir |= b;
                        sgci_pkg::CH_D0: lvl &= ~b;
                        sgci_pkg::CH_D1: lvl |= b;
                        sgci_pkg::CH_UU: begin
                            pu |= b;
                            pd &= ~b;
                        end
                        sgci_pkg::CH_UD: begin
                            pd |= b;
                            pu &= ~b;
                        end
                        sgci_pkg::CH_UN: begin
                            pu &= ~b;
                            pd &= ~b;
                        end
                        sgci_pkg::CH_QUERY: begin
                            chars[0] = sgci_pkg::CH_LA + 8'(pin);
                            chars[1] = ((d.pin_levels & b) != '0) ?
                                       sgci_pkg::CH_D1 : sgci_pkg::CH_D0;
                            chars[2] = sgci_pkg::CH_CR;
                            chars[3] = sgci_pkg::CH_LF;
                            n = 4;
                            queries++;
                        end
                        default: acted = 1'b0;
                    endcase
                    if (acted) begin
                        pin = (pin == 5'(NUM_PINS - 1)) ? 5'd0 : pin + 5'd1;
                    end
                end
            end
            cnt = (n == 0) ? 1 : n;
            for (int k = 0; k < cnt; k++) begin
                r.tx_valid     = (n != 0);
                r.tx_byte      = (n != 0) ? chars[k] : 8'd0;
                r.last         = (k == cnt - 1);
                r.pin_dir      = dir;
                r.pin_out      = lvl;
                r.pull_up_en   = pu;
                r.pull_down_en = pd;
                r.spi_enabled  = spi_on;
                r.spi_strobe   = strobe && k == 0;
                r.spi_tx_byte  = (strobe && k == 0) ? stx : 8'd0;
                expected_responses.push_back(r);
            end
        endfunction

        function void compare(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(sgci_pkg::t_out got);
            sgci_pkg::t_out e;
            responses++;
            if (expected_responses.size() == 0) begin
                $error("response transaction with nothing expected: %0h", got);
                errors++;
                return;
            end
            e = expected_responses.pop_front();
            compare("tx_valid", e.tx_valid, got.tx_valid);
            compare("tx_byte", e.tx_byte, got.tx_byte);
            compare("last", e.last, got.last);
            compare("pin_dir", e.pin_dir, got.pin_dir);
            compare("pin_out", e.pin_out, got.pin_out);
            compare("pull_up_en", e.pull_up_en, got.pull_up_en);
            compare("pull_down_en", e.pull_down_en, got.pull_down_en);
            compare("spi_enabled", e.spi_enabled, got.spi_enabled);
            compare("spi_strobe", e.spi_strobe, got.spi_strobe);
            compare("spi_tx_byte", e.spi_tx_byte, got.spi_tx_byte);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           i_out_stall = 1'b0;
    sgci_pkg::t_in  i_in_data   = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    sgci_pkg::t_out o_out_data;

    command_scoreboard sb = new();

    // Sender burst control; a zero gap limit means a gapless stream
    int burst_left = 1;
    int gap_max    = 0;

    // Receiver stall pattern state
    logic [5:0] stall_tick = '0;
    logic [1:0] stall_mode = '0;

    serial_gpio_command_interpreter_top #(
        .NUM_PINS(NUM_PINS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the edge. Note the command first so
    // that a response in the same edge still finds its expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.take_command(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switch stall pattern whenever the tick counter wraps, between never, light,
    // heavy and long stretches, so stalls hit every response of a command.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == '0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick[4:3] != 2'b11);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender: present one transaction, hold it until accepted, then drop
    // valid for a random gap when the current burst runs out.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic [PIN_W-1:0] lv,
                             input logic [7:0] sr);
        sgci_pkg::t_in d;
        d.rx_byte     = c;
        d.pin_levels  = lv;
        d.spi_rx_byte = sr;
        i_in_data  <= d;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (gap_max > 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
        end
    endtask

    // Send with random pin levels (sometimes all low or all high) and a
    // random SPI return byte
    task automatic send_cmd(input logic [7:0] c);
        logic [PIN_W-1:0] lv;
        case ($urandom_range(0, 5))
            0:       lv = '0;
            1:       lv = '1;
            default: lv = PIN_W'($urandom);
        endcase
        send_byte(c, lv, 8'($urandom_range(0, 255)));
    endtask

    // Hex digit in either case, now and then a byte that is no digit at all
    function automatic logic [7:0] hex_text();
        int v;
        v = $urandom_range(0, 15);
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        if (v < 10) begin
            return sgci_pkg::CH_D0 + 8'(v);
        end
        return (($urandom_range(0, 1) == 1) ? sgci_pkg::CH_LA : sgci_pkg::CH_UA)
               + 8'(v - 10);
    endfunction

    // Mostly well-formed command sequences with random content, the rest
    // line endings, global commands and raw noise
    task automatic random_traffic(input int target);
        int sent;
        int sel;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                send_cmd(sgci_pkg::CH_LA + 8'($urandom_range(0, NUM_PINS - 1)));
                sent++;
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(PIN_CMDS[$urandom_range(0, 7)]);
                    sent++;
                end
            end else if (sel < 45) begin
                send_cmd(PIN_CMDS[$urandom_range(0, 7)]);
                sent++;
            end else if (sel < 60) begin
                // SPI transfer, sometimes with a line ending in the middle
                send_cmd(sgci_pkg::CH_TILDE);
                if ($urandom_range(0, 5) == 0) begin
                    send_cmd(sgci_pkg::CH_CR);
                    sent++;
                end
                send_cmd(hex_text());
                if ($urandom_range(0, 5) == 0) begin
                    send_cmd(sgci_pkg::CH_LF);
                    sent++;
                end
                send_cmd(hex_text());
                sent += 3;
            end else if (sel < 68) begin
                send_cmd(sgci_pkg::CH_QUERY);
                sent++;
            end else if (sel < 72) begin
                send_cmd(sgci_pkg::CH_UR);
                sent++;
            end else if (sel < 76) begin
                send_cmd(sgci_pkg::CH_UV);
                sent++;
            end else if (sel < 86) begin
                send_cmd(($urandom_range(0, 1) == 1) ? sgci_pkg::CH_CR
                                                      : sgci_pkg::CH_LF);
                sent++;
            end else begin
                send_cmd(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: noise at both extremes, pin commands O, 1, U, D, N and I on
        // pins 0 to 5, a query on the last pin with wrap, a letter past the bank, then
        // transfers with line endings, bad digits, and R and V mid-sequence.
        gap_max = 0;
        send_byte(8'h00, '0, 8'h00);
        send_byte(8'hFF, '1, 8'hFF);
        send_cmd(sgci_pkg::CH_LA);
        send_cmd(sgci_pkg::CH_UO);
        send_cmd(sgci_pkg::CH_D1);
        send_cmd(sgci_pkg::CH_UU);
        send_cmd(sgci_pkg::CH_UD);
        send_cmd(sgci_pkg::CH_UN);
        send_cmd(sgci_pkg::CH_UI);
        send_cmd(LAST_PIN_CH);
        send_byte(sgci_pkg::CH_QUERY, '1, 8'h5A);
        send_cmd(BEYOND_PIN_CH);
        send_cmd(sgci_pkg::CH_D0);
        send_cmd(sgci_pkg::CH_TILDE);
        send_cmd(sgci_pkg::CH_CR);
        send_cmd(sgci_pkg::CH_LF_HX);
        send_cmd(sgci_pkg::CH_LF);
        send_byte(sgci_pkg::CH_UF, '0, 8'hFF);
        send_cmd(sgci_pkg::CH_TILDE);
        send_cmd(BAD_LOWER);
        send_byte(BAD_UPPER, '1, 8'h00);
        send_cmd(sgci_pkg::CH_TILDE);
        send_cmd(sgci_pkg::CH_UR);
        send_cmd(sgci_pkg::CH_TILDE);
        send_cmd(sgci_pkg::CH_D9);
        send_cmd(sgci_pkg::CH_UV);

        // Random part in three idling styles: gapless, long gaps, short gaps
        random_traffic(40);
        gap_max    = 6;
        burst_left = $urandom_range(1, 10);
        random_traffic(40);
        gap_max = 2;
        random_traffic(40);
        i_in_valid <= 1'b0;

        // Drain the responses, then let the block idle before the final check
        while (sb.expected_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (sb.expected_responses.size() != 0) begin
            $error("%0d response transactions never arrived",
                   sb.expected_responses.size());
            sb.errors++;
        end
        $display("summary: %0d command bytes, %0d response transactions checked",
                 sb.commands, sb.responses);
        $display("summary: %0d SPI transfers and %0d pin queries predicted",
                 sb.transfers, sb.queries);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #200000;
        $display("tb: errors");
        $finish;
    end

endmodule
